@@ hw/rtl/wtg_pkg.sv @@
// wtg_pkg: shared types, register indexes and constants of the waveform table generator
// no dependencies; imported by the front, back, top level and checker
package wtg_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LEVEL     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LEVEL    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = CFG_INDEX_W'(3);

  // reset values of the level and period registers
  localparam int HIGH_RESET   = 1023;
  localparam int PERIOD_RESET = 65;

  // reload counter width
  localparam int COUNT_W = 16;

  // queue depths between front, back and result port
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // dac word layout
  localparam int DAC_W     = 17;
  localparam int DAC_VAL_W = 16;

  // fixed point sine constants (unsigned Q2.30)
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_NONE     = 2'd3
  } shape_t;

  // taylor series of sin over the first quadrant, horner form, every step truncated
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

endpackage

@@ hw/rtl/wtg_fifo.sv @@
// wtg_fifo: small register queue with push/full and pop/empty sides
// no dependencies; used between front and back and in front of the result port
module wtg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/wtg_front.sv @@
// wtg_front: tick front end, reload countdown and phase counter
// depends on wtg_pkg; issues phase indexes into the queue toward the back
module wtg_front #(
  parameter int TABLE_LEN = 360
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          advance,
  input  logic [wtg_pkg::COUNT_W-1:0]   sample_period,
  output logic                          emit,
  output logic [$clog2(TABLE_LEN)-1:0]  emit_index
);

  import wtg_pkg::*;

  localparam int IW = $clog2(TABLE_LEN);

  logic [IW-1:0]      phase;
  logic [COUNT_W-1:0] countdown;
  logic               tick;

  assign tick       = accept && advance;
  assign emit       = tick && (countdown == '0);
  assign emit_index = phase;

  // countdown and phase update per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      countdown <= '0;
    end else if (tick) begin
      if (countdown != '0) begin
        countdown <= countdown - COUNT_W'(1);
      end else begin
        countdown <= sample_period;
        phase     <= (phase == IW'(TABLE_LEN - 1)) ? '0 : phase + IW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/wtg_back.sv @@
// wtg_back: sample pipeline, quarter-wave sine rom, sine scaling and triangle ramp division
// depends on wtg_pkg; pops phase indexes and writes samples into the result queue
module wtg_back #(
  parameter int TABLE_LEN   = 360,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wtg_pkg::shape_t               wave_shape,
  input  logic [SAMPLE_BITS-1:0]        low_level,
  input  logic [SAMPLE_BITS-1:0]        high_level,
  input  logic                          mid_empty,
  input  logic [$clog2(TABLE_LEN)-1:0]  mid_index,
  output logic                          mid_pop,
  input  logic                          out_fire,
  output logic                          res_valid,
  output logic [SAMPLE_BITS-1:0]        res_value,
  output logic [$clog2(TABLE_LEN)-1:0]  res_index
);

  import wtg_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int IW    = $clog2(TABLE_LEN);
  localparam int HALF  = TABLE_LEN / 2;
  localparam int KW    = $clog2(HALF + 1);
  localparam int NW    = SB + KW;
  localparam int PW    = SB + 17;
  localparam int NUMW  = SB + 18;
  localparam int RW    = $clog2(OUT_DEPTH + 1);
  localparam logic [NW-1:0] RECIP = NW'((64'd1 << NW) / HALF);

  // folded angle positions are multiples of gcd(4, TABLE_LEN)
  localparam int QG  = (TABLE_LEN % 4 == 0) ? 4 : ((TABLE_LEN % 2 == 0) ? 2 : 1);
  localparam int QS  = (QG == 4) ? 2 : ((QG == 2) ? 1 : 0);
  localparam int QN  = TABLE_LEN / QG + 1;
  localparam int QW  = $clog2(QN);
  localparam int KPW = IW + 2;

  // Q0.15 sine magnitude at folded angle position j * QG
  function automatic logic [14:0] sine_mag_q15(input int j);
    logic [63:0] x;
    logic [63:0] m;
    x = (64'(j) * 64'(QG) * HALF_PI_Q30) / TABLE_LEN;
    m = (sine_q30(x) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return 15'(m);
  endfunction

  // constant quarter-wave magnitude rom
  logic [14:0] sine_mag_rom [QN];
  for (genvar g = 0; g < QN; g++) begin : g_rom
    assign sine_mag_rom[g] = sine_mag_q15(g);
  end

  // result queue credit: slots taken by queued and in-flight samples
  logic [RW-1:0] reserved;
  logic          issue;

  assign issue   = !mid_empty && (reserved < RW'(OUT_DEPTH));
  assign mid_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      case ({issue, out_fire})
        2'b10:   reserved <= reserved + RW'(1);
        2'b01:   reserved <= reserved - RW'(1);
        default: reserved <= reserved;
      endcase
    end
  end

  // stage valid bits
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: quadrant fold, rom read and triangle ramp position
  logic [IW-1:0]      r1_idx;
  logic signed [15:0] r1_sin;
  logic [KW-1:0]      r1_k;
  logic [IW:0]        ramp_pos;
  logic [KPW-1:0]     sin_k;
  logic [1:0]         sin_quad;
  logic [KPW-1:0]     sin_r;
  logic [QW-1:0]      rom_addr;

  // quadrant by compare and subtract, mirrored position in odd quadrants
  always_comb begin
    sin_k = KPW'(mid_index) << 2;
    if (sin_k >= KPW'(3 * TABLE_LEN)) begin
      sin_quad = 2'd3;
      sin_r    = sin_k - KPW'(3 * TABLE_LEN);
    end else if (sin_k >= KPW'(2 * TABLE_LEN)) begin
      sin_quad = 2'd2;
      sin_r    = sin_k - KPW'(2 * TABLE_LEN);
    end else if (sin_k >= KPW'(TABLE_LEN)) begin
      sin_quad = 2'd1;
      sin_r    = sin_k - KPW'(TABLE_LEN);
    end else begin
      sin_quad = 2'd0;
      sin_r    = sin_k;
    end
    if (sin_quad[0]) begin
      sin_r = KPW'(TABLE_LEN) - sin_r;
    end
    rom_addr = QW'(sin_r >> QS);
  end

  always_comb begin
    if (mid_index < IW'(HALF)) begin
      ramp_pos = (IW + 1)'(mid_index);
    end else begin
      ramp_pos = (IW + 1)'(TABLE_LEN) - (IW + 1)'(mid_index);
    end
    if (ramp_pos > (IW + 1)'(HALF)) begin
      ramp_pos = (IW + 1)'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      r1_idx <= mid_index;
      r1_sin <= sin_quad[1] ? -signed'({1'b0, sine_mag_rom[rom_addr]})
                            : signed'({1'b0, sine_mag_rom[rom_addr]});
      r1_k   <= KW'(ramp_pos);
    end
  end

  // stage 2: span times sine, span magnitude times ramp position
  // a falling ramp adds HALF-1 so the quotient rounds up, keeping the floor of the level
  logic signed [SB:0]   span;
  logic [SB-1:0]        span_mag;
  logic signed [PW-1:0] r2_ps;
  logic [NW-1:0]        r2_pt;
  logic                 r2_neg;
  logic [IW-1:0]        r2_idx;

  always_comb begin
    span     = signed'({1'b0, high_level}) - signed'({1'b0, low_level});
    span_mag = span[SB] ? SB'(-span) : span[SB-1:0];
  end

  always_ff @(posedge clk) begin
    r2_ps  <= PW'(span) * PW'(r1_sin);
    r2_pt  <= NW'(span_mag) * NW'(r1_k) + (span[SB] ? NW'(HALF - 1) : NW'(0));
    r2_neg <= span[SB];
    r2_idx <= r1_idx;
  end

  // stage 3: sine offset and floor, ramp quotient estimate by reciprocal
  logic signed [NUMW-1:0] sine_base;
  logic signed [NUMW-1:0] sine_num;
  logic [2*NW-1:0]        q_prod;
  logic [SB-1:0]          r3_sine;
  logic [SB-1:0]          r3_q0;
  logic [NW-1:0]          r3_pt;
  logic                   r3_neg;
  logic [IW-1:0]          r3_idx;

  always_comb begin
    sine_base = NUMW'({1'b0, low_level} + {1'b0, high_level}) <<< 15;
    sine_num  = sine_base + NUMW'(r2_ps);
    q_prod    = (2 * NW)'(r2_pt) * (2 * NW)'(RECIP);
  end

  always_ff @(posedge clk) begin
    r3_sine <= sine_num[NUMW-1] ? '0 : sine_num[SB+15:16];
    r3_q0   <= SB'(q_prod >> NW);
    r3_pt   <= r2_pt;
    r3_neg  <= r2_neg;
    r3_idx  <= r2_idx;
  end

  // stage 4: quotient estimate back to a product for the remainder check
  logic [NW-1:0] r4_prod;
  logic [SB-1:0] r4_q0;
  logic [NW-1:0] r4_pt;
  logic          r4_neg;
  logic [SB-1:0] r4_sine;
  logic [IW-1:0] r4_idx;

  always_ff @(posedge clk) begin
    r4_prod <= NW'(r3_q0) * NW'(HALF);
    r4_q0   <= r3_q0;
    r4_pt   <= r3_pt;
    r4_neg  <= r3_neg;
    r4_sine <= r3_sine;
    r4_idx  <= r3_idx;
  end

  // stage 5: quotient correction and shape select
  logic [NW-1:0] ramp_rem;
  logic [SB-1:0] ramp_q;
  logic [SB-1:0] tri_value;

  always_comb begin
    ramp_rem  = r4_pt - r4_prod;
    ramp_q    = r4_q0 + SB'(ramp_rem >= NW'(HALF));
    tri_value = r4_neg ? (low_level - ramp_q) : (low_level + ramp_q);
    unique case (wave_shape)
      SHAPE_SINE:     res_value = r4_sine;
      SHAPE_SQUARE:   res_value = (r4_idx < IW'(HALF)) ? high_level : low_level;
      SHAPE_TRIANGLE: res_value = tri_value;
      SHAPE_NONE:     res_value = '0;
      default:        res_value = '0;
    endcase
  end

  assign res_valid = v4;
  assign res_index = r4_idx;

endmodule

@@ hw/rtl/waveform_table_generator.sv @@
// Periodic table waveform generator: one tick per push transaction, one sample per
// pop transaction. Every cycle can take a tick while full is low; a tick finding
// the reload counter at zero issues the sample at the current phase, and the back
// pipeline turns one phase index a cycle into a sample while result queue credit
// lasts. Samples reach the result queue through the phase queue and the back
// pipeline registers; full rises only when the four-entry phase queue fills, which
// happens when the eight-entry result queue is held by the consumer. Configuration
// writes complete in the cycle they are presented and apply to later samples.
module waveform_table_generator #(
  parameter int TABLE_LEN   = 360,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  // tick queue side
  input  logic                               push,
  output logic                               full,
  input  logic                               advance,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic [wtg_pkg::DAC_W-1:0]          dac_word,
  output logic [SAMPLE_BITS-1:0]             sample_value,
  output logic [$clog2(TABLE_LEN)-1:0]       sample_index,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wtg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import wtg_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int IW = $clog2(TABLE_LEN);

  // configuration registers
  shape_t        wave_shape;
  logic [SB-1:0] low_level;
  logic [SB-1:0] high_level;
  logic [COUNT_W-1:0] sample_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape    <= SHAPE_SINE;
      low_level     <= '0;
      high_level    <= SB'(HIGH_RESET);
      sample_period <= COUNT_W'(PERIOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVE_SHAPE:    wave_shape    <= shape_t'(cfg_data[1:0]);
        CFG_LOW_LEVEL:     low_level     <= cfg_data[SB-1:0];
        CFG_HIGH_LEVEL:    high_level    <= cfg_data[SB-1:0];
        CFG_SAMPLE_PERIOD: sample_period <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: tick handling
  logic          mid_full;
  logic          emit;
  logic [IW-1:0] emit_index;

  assign full = mid_full;

  wtg_front #(
    .TABLE_LEN (TABLE_LEN)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (push && !full),
    .advance       (advance),
    .sample_period (sample_period),
    .emit          (emit),
    .emit_index    (emit_index)
  );

  // phase queue between front and back
  logic          mid_empty;
  logic          mid_pop;
  logic [IW-1:0] mid_index;

  wtg_fifo #(
    .WIDTH (IW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (emit),
    .wdata (emit_index),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_index),
    .empty (mid_empty)
  );

  // back: sample pipeline
  logic          res_valid;
  logic [SB-1:0] res_value;
  logic [IW-1:0] res_index;
  logic          out_full;
  logic          out_fire;

  assign out_fire = pop && !empty;

  wtg_back #(
    .TABLE_LEN   (TABLE_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wave_shape (wave_shape),
    .low_level  (low_level),
    .high_level (high_level),
    .mid_empty  (mid_empty),
    .mid_index  (mid_index),
    .mid_pop    (mid_pop),
    .out_fire   (out_fire),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_index  (res_index)
  );

  // result queue, room guaranteed by the back credit count
  logic [SB+IW-1:0] out_data;

  wtg_fifo #(
    .WIDTH (SB + IW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata ({res_value, res_index}),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  // result fields, power bit set and sample left aligned in the dac word
  assign sample_value = out_data[SB+IW-1:IW];
  assign sample_index = out_data[IW-1:0];
  assign dac_word     = DAC_W'(1 << DAC_VAL_W)
                      | (DAC_W'(sample_value) << (DAC_VAL_W - SB))
                      | DAC_W'(out_full & 1'b0);

endmodule

@@ hw/rtl/wtg_checker.sv @@
// wtg_checker: port level checks of the waveform table generator
// depends on wtg_pkg; bound to the top level at the end of this file
module wtg_checker #(
  parameter int TABLE_LEN   = 360,
  parameter int SAMPLE_BITS = 10
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               push,
  input logic                               full,
  input logic                               advance,
  input logic                               empty,
  input logic                               pop,
  input logic [wtg_pkg::DAC_W-1:0]          dac_word,
  input logic [SAMPLE_BITS-1:0]             sample_value,
  input logic [$clog2(TABLE_LEN)-1:0]       sample_index,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [wtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input logic [wtg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import wtg_pkg::*;

  // no result is waiting right after reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // dac word carries the power bit and the left aligned sample
  a_dac_packing: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (dac_word[DAC_W-1] == 1'b1) &&
               (dac_word[DAC_VAL_W-1:0] ==
                (DAC_VAL_W'(sample_value) << (DAC_VAL_W - SAMPLE_BITS))))
    else $error("dac word does not match sample value");

  // phase position stays inside the cycle
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (32'(sample_index) < TABLE_LEN))
    else $error("sample index beyond the table length");

  // a waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sample_index) && $stable(sample_value)))
    else $error("waiting result changed before pop");

endmodule

bind waveform_table_generator wtg_checker #(
  .TABLE_LEN   (TABLE_LEN),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wtg_checker (.*);
